### hdl/afg_pkg.sv
package afg_pkg;

    localparam int DEF_RING_DEPTH = 4096;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int OVR_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE   = 2'd2;

    // Item kinds on the input tuser
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_PULL = 1'b1;

    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

    // Round half up from Q6.27 to Q1.15, then clamp to the sample range.
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W:0]    biased;
        logic signed [PROD_W-12:0] q;
        biased = {p[PROD_W-1], p} + (PROD_W+1)'(2048);
        q      = biased[PROD_W:12];
        if (q > (PROD_W-11)'(32767)) begin
            round_sat = 16'sh7FFF;
        end else if (q < -(PROD_W-11)'(32768)) begin
            round_sat = 16'sh8000;
        end else begin
            round_sat = q[SAMPLE_W-1:0];
        end
    endfunction

endpackage

### hdl/audio_sample_fifo_gain.sv
// Path: the ring is read at the edge that takes an input word, the gain product goes
// into stage 2, round and clamp into the output register. Throughput: one word per
// cycle when not stalled; the ring RAM does at most one write or one read a cycle.
// Reset (synchronous, active low) clears pointers, fill count, overrun count, pipeline
// valids and config (enable 0, gain unity, mute 0). The ring contents are not cleared.
module audio_sample_fifo_gain #(
    parameter int RING_DEPTH = afg_pkg::DEF_RING_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [afg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [afg_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [afg_pkg::SAMPLE_W-1:0]      i_s_axis_tdata,  // [15:0] sample
    input  logic                              i_s_axis_tuser,  // [0] mode
    // output stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out_sample, fill_level, overrun_total from bit 0 up, zero padded to bytes
    output logic [((afg_pkg::SAMPLE_W + $clog2(RING_DEPTH+1) + afg_pkg::OVR_W + 7) / 8) * 8 - 1:0]
                                              o_m_axis_tdata,
    output logic [1:0]                        o_m_axis_tuser   // [0] from_store, [1] dropped
);

    import afg_pkg::*;

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int ODW = ((SAMPLE_W + CW + OVR_W + 7) / 8) * 8;

    // config
    logic              r_enable;
    logic [GAIN_W-1:0] r_gain;
    logic              r_mute;

    // ring state
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [OVR_W-1:0] r_ovr;

    // stage 1: RAM read pending
    logic              r_s1_v, r_s1_got, r_s1_drop;
    logic [CW-1:0]     r_s1_fill;
    logic [OVR_W-1:0]  r_s1_ovr;
    logic [GAIN_W-1:0] r_s1_gain;

    // stage 2: product held
    logic                     r_s2_v, r_s2_got, r_s2_drop;
    logic [CW-1:0]            r_s2_fill;
    logic [OVR_W-1:0]         r_s2_ovr;
    logic signed [PROD_W-1:0] r_s2_prod;

    // output register
    logic                       r_o_v, r_o_got, r_o_drop;
    logic [CW-1:0]              r_o_fill;
    logic [OVR_W-1:0]           r_o_ovr;
    logic signed [SAMPLE_W-1:0] r_o_sample;

    logic out_adv, s2_free, s1_adv, s1_free, in_acc;
    logic is_push, is_pull, full, empty, do_write, do_read, do_drop;
    logic [AW-1:0]    n_wr_ptr, n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic [OVR_W-1:0] n_ovr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic signed [PROD_W-1:0] prod;

    // pipeline flow
    assign out_adv = r_s2_v && (!r_o_v || i_m_axis_tready);
    assign s2_free = !r_s2_v || out_adv;
    assign s1_adv  = r_s1_v && s2_free;
    assign s1_free = !r_s1_v || s1_adv;
    assign o_s_axis_tready = s1_free;
    assign in_acc  = i_s_axis_tvalid && s1_free;

    assign is_push  = in_acc && (i_s_axis_tuser == MODE_PUSH);
    assign is_pull  = in_acc && (i_s_axis_tuser == MODE_PULL);
    assign full     = (r_count == CW'(RING_DEPTH));
    assign empty    = (r_count == '0);
    assign do_write = is_push && r_enable && !full;
    assign do_drop  = is_push && r_enable && full;
    assign do_read  = is_pull && !empty;

    assign n_wr_ptr = (r_wr_ptr == AW'(RING_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(RING_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_comb begin
        n_count = r_count;
        if (do_write) begin
            n_count = r_count + 1'b1;
        end else if (do_read) begin
            n_count = r_count - 1'b1;
        end
    end

    // saturate the overrun count at all ones
    assign n_ovr = (do_drop && !(&r_ovr)) ? r_ovr + 1'b1 : r_ovr;

    afg_ram #(
        .DATA_W (SAMPLE_W),
        .DEPTH  (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_s_axis_tdata),
        .i_re    (do_read),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign prod = $signed(ram_rdata) * $signed({1'b0, r_s1_gain});

    // config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_gain   <= GAIN_RESET;
            r_mute   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_MUTE:   r_mute   <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_ovr    <= '0;
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_o_v    <= 1'b0;
        end else begin
            if (do_write) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_read) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= n_count;
            r_ovr   <= n_ovr;
            if (s1_free) begin
                r_s1_v <= in_acc;
            end
            if (s2_free) begin
                r_s2_v <= s1_adv;
            end
            if (out_adv) begin
                r_o_v <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // payload: capture status at accept, carry with the word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_got  <= do_read;
            r_s1_drop <= do_drop;
            r_s1_fill <= n_count;
            r_s1_ovr  <= n_ovr;
            r_s1_gain <= r_mute ? '0 : r_gain;
        end
        if (s1_adv) begin
            r_s2_got  <= r_s1_got;
            r_s2_drop <= r_s1_drop;
            r_s2_fill <= r_s1_fill;
            r_s2_ovr  <= r_s1_ovr;
            r_s2_prod <= prod;
        end
        if (out_adv) begin
            r_o_got    <= r_s2_got;
            r_o_drop   <= r_s2_drop;
            r_o_fill   <= r_s2_fill;
            r_o_ovr    <= r_s2_ovr;
            // silence unless a stored sample was taken
            r_o_sample <= r_s2_got ? round_sat(r_s2_prod) : '0;
        end
    end

    assign o_m_axis_tvalid = r_o_v;
    assign o_m_axis_tdata  = ODW'({r_o_ovr, r_o_fill, r_o_sample});
    assign o_m_axis_tuser  = {r_o_drop, r_o_got};

endmodule

### hdl/afg_ram.sv
module afg_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import afg_pkg::*;

    localparam int DEPTH       = DEF_RING_DEPTH;
    localparam int FILL_W      = $clog2(DEPTH + 1);
    localparam int TDATA_W     = ((SAMPLE_W + FILL_W + OVR_W + 7) / 8) * 8;
    localparam int QUIET_LIMIT = 4000;

    // index 3 maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] level;
        logic                       from_store;
        logic                       dropped;
        logic [FILL_W-1:0]          fill;
        logic [OVR_W-1:0]           overruns;
    } t_outcome;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [SAMPLE_W-1:0]  i_s_axis_tdata = '0;
    logic                 i_s_axis_tuser = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   o_m_axis_tdata;
    logic [1:0]           o_m_axis_tuser;

    // shadow of the block: registers and ring
    logic              reg_enable = 1'b0;
    logic [GAIN_W-1:0] reg_gain   = GAIN_RESET;
    logic              reg_mute   = 1'b0;
    logic [SAMPLE_W-1:0] ring_copy [DEPTH];
    int                wr_ptr = 0;
    int                rd_ptr = 0;
    int                held = 0;
    logic [OVR_W-1:0]  overruns = '0;

    t_outcome pending_outcomes [$];
    t_outcome want;
    t_outcome got;
    int       mismatches = 0;
    int       quiet_cycles = 0;
    int       src_gap_pct = 35;
    int       sink_stall_pct = 69;

    always #1 i_clk = ~i_clk;

    audio_sample_fifo_gain #(
        .RING_DEPTH(DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    // Q1.15 times unsigned Q4.12, round half up, clamp
    function automatic logic signed [SAMPLE_W-1:0] apply_gain(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [GAIN_W-1:0]          g
    );
        longint prod;
        prod = longint'(s) * longint'(g) + 64'sd2048;
        prod = prod >>> 12;
        if (prod > 32767) begin
            return 16'sh7FFF;
        end else if (prod < -32768) begin
            return 16'sh8000;
        end
        return prod[SAMPLE_W-1:0];
    endfunction

    function automatic t_outcome predict_outcome(input logic mode, input logic [SAMPLE_W-1:0] smp);
        t_outcome r;
        r = '0;
        if (mode == MODE_PUSH) begin
            if (reg_enable) begin
                if (held == DEPTH) begin
                    r.dropped = 1'b1;
                    if (overruns != '1) overruns = overruns + 1'b1;
                end else begin
                    ring_copy[wr_ptr] = smp;
                    wr_ptr = (wr_ptr + 1) % DEPTH;
                    held++;
                end
            end
        end else if (held != 0) begin
            r.level      = apply_gain(ring_copy[rd_ptr], reg_mute ? '0 : reg_gain);
            r.from_store = 1'b1;
            rd_ptr = (rd_ptr + 1) % DEPTH;
            held--;
        end
        r.fill     = held[FILL_W-1:0];
        r.overruns = overruns;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int k;
        k = $urandom_range(7);
        case (k)
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic offer_word(input logic mode, input logic [SAMPLE_W-1:0] smp);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99) < src_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= smp;
        i_s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_outcomes.push_back(predict_outcome(mode, smp));
    endtask

    // leaves the valid high so that writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ENABLE: reg_enable = val[0];
            CFG_GAIN:   reg_gain   = val;
            CFG_MUTE:   reg_mute   = val[0];
            default: ;
        endcase
    endtask

    // hold off until every result word is back and the pipeline is empty
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid     <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_directed_edges();
        // reset values: disabled, unity gain
        offer_word(MODE_PUSH, 16'd100);
        offer_word(MODE_PULL, 16'hFFFF);
        settle();
        write_reg(CFG_ENABLE, 16'd1);
        offer_word(MODE_PUSH, 16'h7FFF);
        offer_word(MODE_PUSH, 16'h8000);
        offer_word(MODE_PUSH, 16'h0000);
        offer_word(MODE_PUSH, 16'hFFFF);
        repeat (4) offer_word(MODE_PULL, 16'h0000);
        // top gain drives both rails into the clamp
        settle();
        write_reg(CFG_GAIN, 16'hFFFF);
        offer_word(MODE_PUSH, 16'h7FFF);
        offer_word(MODE_PUSH, 16'h8000);
        repeat (2) offer_word(MODE_PULL, 16'h5A5A);
        // half gain lands odd samples exactly on the rounding midpoint
        settle();
        write_reg(CFG_GAIN, 16'd2048);
        offer_word(MODE_PUSH, 16'h0001);
        offer_word(MODE_PUSH, 16'hFFFF);
        offer_word(MODE_PUSH, 16'h0003);
        repeat (3) offer_word(MODE_PULL, 16'h0000);
        settle();
        write_reg(CFG_MUTE, 16'd1);
        offer_word(MODE_PUSH, 16'd12345);
        offer_word(MODE_PULL, 16'h0000);
        settle();
        write_reg(CFG_MUTE, 16'd0);
        write_reg(CFG_SPARE, 16'hFFFF);
        offer_word(MODE_PUSH, 16'd777);
        // pulls still drain while disabled
        settle();
        write_reg(CFG_ENABLE, 16'd0);
        offer_word(MODE_PULL, 16'h0000);
        offer_word(MODE_PUSH, 16'd5);
    endtask

    task automatic test_random_phases();
        int enables[6]  = '{1, 1, 1, 1, 0, 1};
        int gains[6]    = '{-1, 65535, 0, -1, 4096, -2};
        int mutes[6]    = '{0, 0, 0, 1, 0, 0};
        int push_pct[6] = '{60, 50, 45, 50, 50, 40};
        int targets[6]  = '{300, 300, 300, 250, 80, 300};
        int served;
        logic mode;
        logic [GAIN_W-1:0] g;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                src_gap_pct    = 69;
                sink_stall_pct = 35;
            end else if (ph == 4) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            settle();
            if (gains[ph] == -1) begin
                g = 16'($urandom_range(65535));
            end else if (gains[ph] == -2) begin
                g = 16'($urandom_range(8191));
            end else begin
                g = 16'(gains[ph]);
            end
            write_reg(CFG_ENABLE, 16'(enables[ph]));
            write_reg(CFG_GAIN, g);
            write_reg(CFG_MUTE, 16'(mutes[ph]));
            served = 0;
            while (served < targets[ph]) begin
                mode = ($urandom_range(99) < push_pct[ph]) ? MODE_PUSH : MODE_PULL;
                offer_word(mode, pick_sample());
                if (mode == MODE_PULL || reg_enable) served++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.level      = o_m_axis_tdata[SAMPLE_W-1:0];
                got.fill       = o_m_axis_tdata[SAMPLE_W +: FILL_W];
                got.overruns   = o_m_axis_tdata[SAMPLE_W + FILL_W +: OVR_W];
                got.from_store = o_m_axis_tuser[0];
                got.dropped    = o_m_axis_tuser[1];
                if (pending_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result word: tdata %h tuser %b",
                                 o_m_axis_tdata, o_m_axis_tuser);
                    end
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.level !== want.level || got.from_store !== want.from_store ||
                        got.dropped !== want.dropped || got.fill !== want.fill ||
                        got.overruns !== want.overruns) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp sample %0d store %b drop %b fill %0d ovr %0d",
                                     want.level, want.from_store, want.dropped, want.fill,
                                     want.overruns);
                            $display("          got sample %0d store %b drop %b fill %0d ovr %0d",
                                     got.level, got.from_store, got.dropped, got.fill,
                                     got.overruns);
                        end
                    end
                end
            end
        end
    end

    // end the run if no word moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_random_phases();
        settle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
